[hdl/asm_tok_pkg.sv]
// ----------------------------------------------------------------------------
// asm_tok_pkg
// Token kinds, token record and queue push bundle shared by the tokenizer.
// ----------------------------------------------------------------------------
package asm_tok_pkg;

    localparam int OUT_W  = 24;
    localparam int KIND_W = 5;

    localparam logic [KIND_W-1:0] K_EOF      = 5'd0;
    localparam logic [KIND_W-1:0] K_NEWLINE  = 5'd1;
    localparam logic [KIND_W-1:0] K_COLON    = 5'd2;
    localparam logic [KIND_W-1:0] K_LBRACKET = 5'd3;
    localparam logic [KIND_W-1:0] K_RBRACKET = 5'd4;
    localparam logic [KIND_W-1:0] K_LPAREN   = 5'd5;
    localparam logic [KIND_W-1:0] K_RPAREN   = 5'd6;
    localparam logic [KIND_W-1:0] K_LBRACE   = 5'd7;
    localparam logic [KIND_W-1:0] K_RBRACE   = 5'd8;
    localparam logic [KIND_W-1:0] K_COMMA    = 5'd9;
    localparam logic [KIND_W-1:0] K_EQUAL    = 5'd10;
    localparam logic [KIND_W-1:0] K_STRING   = 5'd11;
    localparam logic [KIND_W-1:0] K_HEX      = 5'd12;
    localparam logic [KIND_W-1:0] K_INT      = 5'd13;
    localparam logic [KIND_W-1:0] K_FLOAT    = 5'd14;
    localparam logic [KIND_W-1:0] K_IDENT    = 5'd15;
    localparam logic [KIND_W-1:0] K_UNKNOWN  = 5'd16;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [OUT_W-1:0]  start_offset;
        logic [OUT_W-1:0]  token_length;
        logic [OUT_W-1:0]  line_number;
        logic [OUT_W-1:0]  column_number;
        logic              last_of_run;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } tok_push_t;

endpackage

[hdl/asm_tok_scan.sv]
// ----------------------------------------------------------------------------
// asm_tok_scan
// Scanner state and counters; turns one accepted byte or end marker into
// up to two tokens pushed to the output queue in the same cycle.
// ----------------------------------------------------------------------------
module asm_tok_scan #(
    parameter int POS_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            byte_value,
    input  logic                  end_of_input,
    output asm_tok_pkg::tok_push_t push
);
    import asm_tok_pkg::*;

    localparam int MW = (POS_BITS > OUT_W) ? POS_BITS : OUT_W;
    localparam logic [POS_BITS-1:0] CNT_MAX = '1;
    localparam logic [POS_BITS-1:0] CNT_ONE = POS_BITS'(1);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_CR      = 4'd1;
    localparam logic [3:0] M_IDENT   = 4'd2;
    localparam logic [3:0] M_ZERO    = 4'd3;
    localparam logic [3:0] M_INT     = 4'd4;
    localparam logic [3:0] M_FLOAT   = 4'd5;
    localparam logic [3:0] M_HEX     = 4'd6;
    localparam logic [3:0] M_MINUS   = 4'd7;
    localparam logic [3:0] M_STR     = 4'd8;
    localparam logic [3:0] M_STR_ESC = 4'd9;
    localparam logic [3:0] M_SLASH   = 4'd10;
    localparam logic [3:0] M_COMMENT = 4'd11;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] x);
        sat_inc = (x == CNT_MAX) ? x : x + CNT_ONE;
    endfunction

    function automatic logic [OUT_W-1:0] trim(input logic [POS_BITS-1:0] x);
        logic [MW-1:0] w;
        w = MW'(x);
        trim = w[OUT_W-1:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_xdigit(input logic [7:0] b);
        is_xdigit = is_digit(b) || ((b >= 8'h61) && (b <= 8'h66))
                    || ((b >= 8'h41) && (b <= 8'h46));
    endfunction

    function automatic logic is_id_cont(input logic [7:0] b);
        is_id_cont = is_alpha(b) || is_digit(b) || (b == CH_UNDER) || (b == CH_DOT);
    endfunction

    function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] b);
        case (b)
            8'h3A:   punct_kind = K_COLON;
            8'h5B:   punct_kind = K_LBRACKET;
            8'h5D:   punct_kind = K_RBRACKET;
            8'h28:   punct_kind = K_LPAREN;
            8'h29:   punct_kind = K_RPAREN;
            8'h7B:   punct_kind = K_LBRACE;
            8'h7D:   punct_kind = K_RBRACE;
            8'h2C:   punct_kind = K_COMMA;
            8'h3D:   punct_kind = K_EQUAL;
            default: punct_kind = K_EOF;
        endcase
    endfunction

    logic [3:0]          mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] line_reg, line_next;
    logic [POS_BITS-1:0] col_reg, col_next;
    logic [POS_BITS-1:0] tstart_reg, tstart_next;
    logic [POS_BITS-1:0] tline_reg, tline_next;
    logic [POS_BITS-1:0] tcol_reg, tcol_next;

    logic [POS_BITS-1:0] pos_inc, line_inc, col_inc;
    logic [POS_BITS-1:0] a_end;
    logic [POS_BITS-1:0] s_line, s_col, s_line_inc, s_col_inc;
    logic                a_emit, b_emit, restart, cr_nl, cont_nl;
    logic [KIND_W-1:0]   a_kind, b_kind, pk;
    logic [3:0]          cont_mode;
    token_t              tok_a, tok_b;

    always_comb
    begin
        pos_inc  = sat_inc(pos_reg);
        line_inc = sat_inc(line_reg);
        col_inc  = sat_inc(col_reg);
        pk       = punct_kind(byte_value);

        a_emit    = 1'b0;
        a_kind    = K_EOF;
        a_end     = pos_reg;
        b_emit    = 1'b0;
        b_kind    = K_EOF;
        restart   = 1'b0;
        cr_nl     = 1'b0;
        cont_nl   = 1'b0;
        cont_mode = mode_reg;

        mode_next   = mode_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        tstart_next = tstart_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;

        if (end_of_input)
        begin
            case (mode_reg)
                M_CR:
                begin
                    a_emit = 1'b1;
                    a_kind = K_NEWLINE;
                    cr_nl  = 1'b1;
                end
                M_IDENT, M_MINUS:
                begin
                    a_emit = 1'b1;
                    a_kind = K_IDENT;
                end
                M_ZERO, M_INT:
                begin
                    a_emit = 1'b1;
                    a_kind = K_INT;
                end
                M_FLOAT:
                begin
                    a_emit = 1'b1;
                    a_kind = K_FLOAT;
                end
                M_HEX:
                begin
                    a_emit = 1'b1;
                    a_kind = K_HEX;
                end
                M_STR, M_STR_ESC:
                begin
                    a_emit = 1'b1;
                    a_kind = K_STRING;
                end
                M_SLASH:
                begin
                    a_emit = 1'b1;
                    a_kind = K_UNKNOWN;
                end
                default:
                begin
                    a_emit = 1'b0;
                end
            endcase
            b_emit = 1'b1;
            b_kind = K_EOF;

            mode_next   = M_IDLE;
            pos_next    = '0;
            line_next   = CNT_ONE;
            col_next    = CNT_ONE;
            tstart_next = '0;
            tline_next  = CNT_ONE;
            tcol_next   = CNT_ONE;
        end
        else
        begin
            case (mode_reg)
                M_CR:
                begin
                    a_emit = 1'b1;
                    a_kind = K_NEWLINE;
                    if (byte_value == CH_LF)
                    begin
                        a_end     = pos_inc;
                        cont_nl   = 1'b1;
                        cont_mode = M_IDLE;
                    end
                    else
                    begin
                        restart = 1'b1;
                        cr_nl   = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (!is_id_cont(byte_value))
                    begin
                        restart = 1'b1;
                        a_emit  = 1'b1;
                        a_kind  = K_IDENT;
                    end
                end
                M_ZERO, M_INT:
                begin
                    if ((mode_reg == M_ZERO)
                        && ((byte_value == CH_X_LO) || (byte_value == CH_X_UP)))
                    begin
                        cont_mode = M_HEX;
                    end
                    else if (is_digit(byte_value))
                    begin
                        cont_mode = M_INT;
                    end
                    else if (byte_value == CH_DOT)
                    begin
                        cont_mode = M_FLOAT;
                    end
                    else
                    begin
                        restart = 1'b1;
                        a_emit  = 1'b1;
                        a_kind  = K_INT;
                    end
                end
                M_FLOAT:
                begin
                    if (!is_digit(byte_value))
                    begin
                        restart = 1'b1;
                        a_emit  = 1'b1;
                        a_kind  = K_FLOAT;
                    end
                end
                M_HEX:
                begin
                    if (!is_xdigit(byte_value))
                    begin
                        restart = 1'b1;
                        a_emit  = 1'b1;
                        a_kind  = K_HEX;
                    end
                end
                M_MINUS:
                begin
                    if (is_digit(byte_value))
                    begin
                        cont_mode = M_INT;
                    end
                    else if (is_id_cont(byte_value))
                    begin
                        cont_mode = M_IDENT;
                    end
                    else
                    begin
                        restart = 1'b1;
                        a_emit  = 1'b1;
                        a_kind  = K_IDENT;
                    end
                end
                M_STR:
                begin
                    if (byte_value == CH_QUOTE)
                    begin
                        a_emit    = 1'b1;
                        a_kind    = K_STRING;
                        a_end     = pos_inc;
                        cont_mode = M_IDLE;
                    end
                    else if (byte_value == CH_BSLASH)
                    begin
                        cont_mode = M_STR_ESC;
                    end
                end
                M_STR_ESC:
                begin
                    cont_mode = M_STR;
                end
                M_SLASH:
                begin
                    if (byte_value == CH_SLASH)
                    begin
                        cont_mode = M_COMMENT;
                    end
                    else
                    begin
                        restart = 1'b1;
                        a_emit  = 1'b1;
                        a_kind  = K_UNKNOWN;
                    end
                end
                M_COMMENT:
                begin
                    if ((byte_value == CH_LF) || (byte_value == CH_CR))
                    begin
                        restart = 1'b1;
                    end
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase

            if (restart)
            begin
                tstart_next = pos_reg;
                tline_next  = s_line;
                tcol_next   = s_col;
                pos_next    = pos_inc;
                line_next   = s_line;
                col_next    = s_col_inc;
                mode_next   = M_IDLE;
                if (byte_value == CH_LF)
                begin
                    b_emit    = 1'b1;
                    b_kind    = K_NEWLINE;
                    line_next = s_line_inc;
                    col_next  = CNT_ONE;
                end
                else if (pk != K_EOF)
                begin
                    b_emit = 1'b1;
                    b_kind = pk;
                end
                else if ((byte_value == CH_SPACE) || (byte_value == CH_TAB))
                begin
                    mode_next = M_IDLE;
                end
                else if (byte_value == CH_CR)
                begin
                    mode_next = M_CR;
                end
                else if (byte_value == CH_QUOTE)
                begin
                    mode_next = M_STR;
                end
                else if (byte_value == CH_ZERO)
                begin
                    mode_next = M_ZERO;
                end
                else if (is_digit(byte_value))
                begin
                    mode_next = M_INT;
                end
                else if (byte_value == CH_MINUS)
                begin
                    mode_next = M_MINUS;
                end
                else if (byte_value == CH_SLASH)
                begin
                    mode_next = M_SLASH;
                end
                else if (is_alpha(byte_value) || (byte_value == CH_UNDER))
                begin
                    mode_next = M_IDENT;
                end
                else
                begin
                    b_emit = 1'b1;
                    b_kind = K_UNKNOWN;
                end
            end
            else
            begin
                mode_next = cont_mode;
                pos_next  = pos_inc;
                col_next  = cont_nl ? CNT_ONE : col_inc;
                line_next = cont_nl ? line_inc : line_reg;
            end
        end
    end

    assign s_line     = cr_nl ? line_inc : line_reg;
    assign s_col      = cr_nl ? CNT_ONE : col_reg;
    assign s_line_inc = sat_inc(s_line);
    assign s_col_inc  = sat_inc(s_col);

    always_comb
    begin
        tok_a.token_kind    = a_kind;
        tok_a.start_offset  = trim(tstart_reg);
        tok_a.token_length  = trim(a_end - tstart_reg);
        tok_a.line_number   = trim(tline_reg);
        tok_a.column_number = trim(tcol_reg);
        tok_a.last_of_run   = !b_emit;

        tok_b.token_kind    = b_kind;
        tok_b.start_offset  = trim(pos_reg);
        tok_b.token_length  = end_of_input ? '0 : trim(pos_inc - pos_reg);
        tok_b.line_number   = trim(s_line);
        tok_b.column_number = trim(s_col);
        tok_b.last_of_run   = 1'b1;

        push.count  = 2'({1'b0, a_emit} + {1'b0, b_emit});
        push.first  = a_emit ? tok_a : tok_b;
        push.second = tok_b;
        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            line_reg   <= CNT_ONE;
            col_reg    <= CNT_ONE;
            tstart_reg <= '0;
            tline_reg  <= CNT_ONE;
            tcol_reg   <= CNT_ONE;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            tstart_reg <= tstart_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
        end
    end

endmodule

[hdl/asm_tok_fifo.sv]
// ----------------------------------------------------------------------------
// asm_tok_fifo
// Four-entry token queue that takes up to two tokens a cycle and hands out one.
// ----------------------------------------------------------------------------
module asm_tok_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  asm_tok_pkg::tok_push_t push,
    output logic                   space_ok,
    output logic                   out_valid,
    input  logic                   out_ready,
    output asm_tok_pkg::token_t    out_token
);
    import asm_tok_pkg::*;

    token_t     entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign space_ok  = (count_reg < 3'd3);
    assign out_valid = (count_reg != 3'd0);
    assign out_token = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/assembly_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// assembly_text_tokenizer
// Streaming tokenizer for assembly-style text, one byte per request.
// ----------------------------------------------------------------------------
// A byte request is scanned in the cycle it is accepted and its tokens (none,
// one or two) enter a four-entry output queue; the first appears on the
// master side after any older tokens. The slave side takes a new request every
// cycle while the queue holds at most two tokens, so the block sustains one
// byte per cycle whenever the sink takes each token as it comes; bursts that
// yield two tokens per byte are limited by the master port, which hands out
// one token per cycle. A request with tlast set flushes any pending token,
// sends an end-of-file token and returns the scanner to its reset state.
module assembly_text_tokenizer #(
    parameter int POS_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // start_offset, token_length, line_number, column_number
    output logic [4:0]  m_tuser,   // token_kind
    output logic        m_tlast    // last_of_run
);
    import asm_tok_pkg::*;

    tok_push_t push;
    token_t    out_token;
    logic      accept;
    logic      space_ok;

    assign s_tready = space_ok;
    assign accept   = s_tvalid && space_ok;

    asm_tok_scan #(
        .POS_BITS(POS_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .byte_value   (s_tdata),
        .end_of_input (s_tlast),
        .push         (push)
    );

    asm_tok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_token (out_token)
    );

    assign m_tdata = {out_token.column_number, out_token.line_number,
                      out_token.token_length, out_token.start_offset};
    assign m_tuser = out_token.token_kind;
    assign m_tlast = out_token.last_of_run;

endmodule

[hdl/asm_tok_checker.sv]
// ----------------------------------------------------------------------------
// asm_tok_checker
// Port-level checks on the tokenizer output stream, bound to the top level.
// ----------------------------------------------------------------------------
module asm_tok_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [4:0]  m_tuser,
    input logic        m_tlast
);
    import asm_tok_pkg::*;

    // A stalled token keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("token changed while stalled");

    // The end-of-file token is empty and closes its run.
    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == K_EOF) |-> m_tlast && (m_tdata[47:24] == 24'd0))
        else $error("malformed end-of-file token");

    // Token kinds stay within the defined range.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= K_UNKNOWN))
        else $error("token kind out of range");

    // Newlines span at most two bytes and single-byte marks at most one.
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser >= K_COLON) && (m_tuser <= K_EQUAL)
        |-> (m_tdata[47:24] <= 24'd1))
        else $error("punctuation token too long");

    a_newline: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == K_NEWLINE) |-> (m_tdata[47:24] <= 24'd2))
        else $error("newline token too long");

endmodule

bind assembly_text_tokenizer asm_tok_checker u_asm_tok_checker (.*);
